@@ src/mpjs_pkg.sv @@
// ----------------------------------------------------------------------------
// mpjs_pkg
// Shared types and constants of the multi-policy job scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mpjs_pkg;
    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_FIFO = 3'd1;
    localparam logic [2:0] POL_RR   = 3'd2;
    localparam logic [2:0] POL_SJF  = 3'd3;
    localparam logic [2:0] POL_SRT  = 3'd4;
    localparam logic [2:0] POL_HRRN = 3'd5;
    localparam logic [2:0] POL_MLFQ = 3'd6;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_RR     = 2'd1;
    localparam logic [1:0] CFG_TOP    = 2'd2;
    localparam logic [1:0] CFG_MID    = 2'd3;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DISP   = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    localparam logic OP_SUBMIT = 1'b0;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  kind;
        logic [4:0]  burst;
        logic [4:0]  left;
        logic [31:0] arrival;
        logic [31:0] wait_t;
        logic [1:0]  level;
    } t_entry;

    // per-cycle command to every cell
    typedef struct packed {
        logic shift;      // load from right neighbor (compaction)
        logic refresh;    // wait <= now - arrival
        logic [31:0] now;
    } t_cell_ctl;
endpackage
`default_nettype wire

@@ src/mpjs_cell.sv @@
// ----------------------------------------------------------------------------
// mpjs_cell
// One job slot: holds an entry, shifts left on removal, refreshes its wait.
// ----------------------------------------------------------------------------
`default_nettype none
module mpjs_cell
    import mpjs_pkg::*;
(
    input  wire logic      i_clk,
    input  t_cell_ctl      i_ctl,
    input  wire logic      i_shift_en,
    input  wire logic      i_load,
    input  t_entry         i_load_data,
    input  t_entry         i_right,
    input  wire logic      i_refresh_en,
    input  wire logic      i_dec,
    output t_entry         o_entry
);
    t_entry r_e, n_e;
    always_comb begin
        n_e = r_e;
        if (i_ctl.shift && i_shift_en) begin
            n_e = i_right;
        end else if (i_load) begin
            n_e = i_load_data;
        end else if (i_dec) begin
            n_e.left = r_e.left - 5'd1;
        end
        if (i_ctl.refresh && i_refresh_en) begin
            n_e.wait_t = i_ctl.now - r_e.arrival;
        end
    end
    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end
    assign o_entry = r_e;
endmodule
`default_nettype wire

@@ src/multi_policy_job_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler_core
// Job table as a row of cells; dispatch scans one cell per cycle.
// ----------------------------------------------------------------------------
// Submit and idle tick: result valid in the cycle after accept.
// Dispatch of n jobs picking slot s runs S_SCAN over the other slots, S_EXEC, S_SHIFT
// from slot s to the end (none for an unfinished SRT tick), S_TAIL refresh, then S_OUT;
// each next accept comes in the cycle after the result transaction. One item at a time.
// Synchronous active-low reset clears counters, clock and handshake and restores config defaults.
`default_nettype none
module multi_policy_job_scheduler_core
    import mpjs_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [0:0]  i_opcode,
    input  wire logic [1:0]  i_job_kind,
    input  wire logic [4:0]  i_burst_len,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_job_id,
    output logic [1:0]       o_job_type_out,
    output logic [4:0]       o_run_ticks,
    output logic [4:0]       o_left_ticks,
    output logic             o_start_note,
    output logic             o_done_note,
    output logic [31:0]      o_now_ticks,
    output logic [4:0]       o_pending
);
    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_TAIL  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [2:0]  r_policy;
    logic [4:0]  r_rr, r_top, r_mid;
    logic [CW-1:0] r_count;
    logic [15:0] r_next_id;
    logic [31:0] r_now;
    logic        r_srt_v;
    logic [15:0] r_srt_id;
    logic [IW-1:0] r_scan, r_sel, r_pos;
    t_entry      r_best, r_hold;
    logic        r_requeue;

    logic        r_ov;
    logic [1:0]  r_st;
    logic [15:0] r_jid;
    logic [1:0]  r_jt;
    logic [4:0]  r_run, r_left;
    logic        r_start, r_done;

    t_entry    w_e [MAX_JOBS];
    t_cell_ctl w_ctl;
    logic [MAX_JOBS-1:0] w_shift_en, w_load, w_ref_en, w_dec;
    t_entry    w_load_data;

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++) begin : g_cell
            t_entry w_r;
            if (g == MAX_JOBS - 1) begin : g_last
                assign w_r = w_e[g];
            end else begin : g_mid
                assign w_r = w_e[g+1];
            end
            mpjs_cell u_cell (
                .i_clk(i_clk), .i_ctl(w_ctl), .i_shift_en(w_shift_en[g]),
                .i_load(w_load[g]), .i_load_data(w_load_data), .i_right(w_r),
                .i_refresh_en(w_ref_en[g]), .i_dec(w_dec[g]), .o_entry(w_e[g])
            );
        end
    endgenerate

    wire logic w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_ov;
    wire logic [CW-1:0] w_max = CW'(MAX_JOBS);
    wire logic [IW-1:0] w_last = IW'(r_count - CW'(1));
    t_entry w_cur;
    assign w_cur = w_e[r_scan];

    // candidate better than best
    logic w_better;
    logic [37:0] w_a, w_b;
    always_comb begin
        w_a = 38'(({1'b0, w_cur.wait_t} + 33'(w_cur.burst)) * r_best.burst);
        w_b = 38'(({1'b0, r_best.wait_t} + 33'(r_best.burst)) * w_cur.burst);
        case (r_policy)
            POL_SJF, POL_SRT: w_better = w_cur.left < r_best.left;
            POL_HRRN:         w_better = w_a > w_b;
            POL_MLFQ:         w_better = w_cur.level < r_best.level;
            default:          w_better = 1'b0;
        endcase
    end

    logic [4:0] w_slice;
    logic       w_sliced;
    always_comb begin
        w_slice = 5'd0;
        w_sliced = 1'b0;
        if (r_policy == POL_RR) begin
            w_sliced = 1'b1;
            w_slice = (r_rr == 5'd0) ? 5'd1 : r_rr;
        end else if (r_policy == POL_MLFQ && r_best.level == 2'd0) begin
            w_sliced = 1'b1;
            w_slice = (r_top == 5'd0) ? 5'd1 : r_top;
        end else if (r_policy == POL_MLFQ && r_best.level == 2'd1) begin
            w_sliced = 1'b1;
            w_slice = (r_mid == 5'd0) ? 5'd1 : r_mid;
        end
    end

    always_comb begin
        w_ctl.shift = (r_state == S_SHIFT);
        w_ctl.refresh = (r_state == S_TAIL);
        w_ctl.now = r_now;
        w_shift_en = '0;
        w_load = '0;
        w_ref_en = '0;
        w_dec = '0;
        w_load_data = r_hold;
        for (int k = 0; k < MAX_JOBS; k++) begin
            w_shift_en[k] = (IW'(k) == r_pos);
            w_ref_en[k] = (CW'(k) < r_count) && !(r_requeue && IW'(k) == w_last)
                          && !(r_policy == POL_SRT && !r_done && IW'(k) == r_sel);
        end
        if (r_state == S_IDLE && w_acc && i_opcode == OP_SUBMIT && r_count < w_max) begin
            w_load[r_count[IW-1:0]] = 1'b1;
            w_load_data.id = r_next_id;
            w_load_data.kind = i_job_kind;
            w_load_data.burst = (i_burst_len == 5'd0) ? 5'd1 : i_burst_len;
            w_load_data.left = w_load_data.burst;
            w_load_data.arrival = r_now;
            w_load_data.wait_t = '0;
            w_load_data.level = 2'd0;
        end else if (r_state == S_TAIL && r_requeue) begin
            w_load[w_last] = 1'b1;
        end
        if (r_state == S_EXEC && r_policy == POL_SRT) begin
            w_dec[r_sel] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_policy <= POL_FCFS;
            r_rr <= 5'd5; r_top <= 5'd5; r_mid <= 5'd10;
            r_count <= '0; r_next_id <= '0; r_now <= '0;
            r_srt_v <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY: r_policy <= i_cfg_data[2:0];
                    CFG_RR:     r_rr <= i_cfg_data;
                    CFG_TOP:    r_top <= i_cfg_data;
                    CFG_MID:    r_mid <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_jt <= 2'd0; r_run <= 5'd0; r_left <= 5'd0;
                        r_start <= 1'b0; r_done <= 1'b0; r_jid <= 16'd0;
                        if (i_opcode == OP_SUBMIT) begin
                            r_ov <= 1'b1;
                            if (r_count < w_max) begin
                                r_st <= ST_ACCEPT; r_jid <= r_next_id;
                                r_next_id <= r_next_id + 16'd1;
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_st <= ST_FULL;
                            end
                        end else if (r_count == '0) begin
                            r_ov <= 1'b1; r_st <= ST_IDLE; r_now <= r_now + 32'd1;
                        end else begin
                            r_best <= w_e[0]; r_sel <= '0; r_scan <= IW'(1);
                            r_state <= (r_count == CW'(1)) ? S_EXEC : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_best <= w_cur; r_sel <= r_scan;
                    end
                    if (r_scan == w_last) r_state <= S_EXEC;
                    r_scan <= r_scan + IW'(1);
                end
                S_EXEC: begin
                    r_st <= ST_DISP; r_jid <= r_best.id; r_jt <= r_best.kind;
                    r_start <= 1'b1; r_pos <= r_sel;
                    r_hold <= r_best; r_requeue <= 1'b0;
                    if (r_policy == POL_SRT) begin
                        r_start <= !(r_srt_v && r_srt_id == r_best.id);
                        r_srt_v <= 1'b1; r_srt_id <= r_best.id;
                        r_run <= 5'd1; r_left <= r_best.left - 5'd1;
                        r_now <= r_now + 32'd1;
                        r_done <= (r_best.left == 5'd1);
                        r_state <= (r_best.left == 5'd1) ? S_SHIFT : S_TAIL;
                    end else if (w_sliced && r_best.left > w_slice) begin
                        r_run <= w_slice; r_left <= r_best.left - w_slice;
                        r_now <= r_now + 32'(w_slice);
                        r_hold.left <= r_best.left - w_slice;
                        if (r_policy == POL_MLFQ && r_best.level < 2'd2)
                            r_hold.level <= r_best.level + 2'd1;
                        r_requeue <= 1'b1; r_done <= 1'b0;
                        r_state <= S_SHIFT;
                    end else begin
                        r_run <= r_best.left; r_left <= 5'd0;
                        r_now <= r_now + 32'(r_best.left);
                        r_done <= 1'b1; r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (CW'(r_pos) + CW'(1) >= r_count) begin
                        if (!r_requeue) r_count <= r_count - CW'(1);
                        r_state <= S_TAIL;
                    end else begin
                        r_pos <= r_pos + IW'(1);
                    end
                end
                S_TAIL: begin
                    r_pos <= '1;
                    r_ov <= 1'b1; r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_job_id = r_jid;
    assign o_job_type_out = r_jt;
    assign o_run_ticks = r_run;
    assign o_left_ticks = r_left;
    assign o_start_note = r_start;
    assign o_done_note = r_done;
    assign o_now_ticks = r_now;
    assign o_pending = 5'(r_count);
endmodule
`default_nettype wire

@@ dv/tb_multi_policy_job_scheduler_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_policy_job_scheduler_core
// Drives submit and dispatch transactions into the job scheduler under every
// policy and several slice settings. A scoreboard keeps its own copy of the
// job table and flags each result field that differs from the prediction.
// Random idling on both sides, a long receiver hold-off and drained pauses
// with register writes in between.
// ----------------------------------------------------------------------------
module tb_multi_policy_job_scheduler_core;
    import mpjs_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] id;
        logic [1:0]  kind;
        logic [4:0]  run;
        logic [4:0]  left;
        logic        start;
        logic        done;
        logic [31:0] now;
        logic [4:0]  pending;
    } t_result;

    class sched_scoreboard;
        t_result     expected_q[$];
        int          errors;
        logic [2:0]  pol;
        logic [4:0]  rr_sl, top_sl, mid_sl;
        logic [15:0] tab_id[DEPTH];
        logic [1:0]  tab_kind[DEPTH];
        logic [4:0]  tab_burst[DEPTH];
        logic [4:0]  tab_left[DEPTH];
        logic [31:0] tab_arr[DEPTH];
        logic [31:0] tab_wait[DEPTH];
        logic [1:0]  tab_lvl[DEPTH];
        int          count;
        logic [15:0] next_id;
        logic [31:0] clk_now;
        logic [16:0] last_srt;

        function new();
            errors = 0; pol = POL_FCFS; rr_sl = 5; top_sl = 5; mid_sl = 10;
            count = 0; next_id = 0; clk_now = 0; last_srt = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [4:0] val);
            case (idx)
                CFG_POLICY: pol = val[2:0];
                CFG_RR:     rr_sl = val;
                CFG_TOP:    top_sl = val;
                default:    mid_sl = val;
            endcase
        endfunction

        function void remove_at(int k);
            for (int i = k; i + 1 < count; i++) begin
                tab_id[i] = tab_id[i+1]; tab_kind[i] = tab_kind[i+1];
                tab_burst[i] = tab_burst[i+1]; tab_left[i] = tab_left[i+1];
                tab_arr[i] = tab_arr[i+1]; tab_wait[i] = tab_wait[i+1];
                tab_lvl[i] = tab_lvl[i+1];
            end
            count--;
        endfunction

        function void update_waits(int skip);
            for (int i = 0; i < count; i++)
                if (i != skip) tab_wait[i] = clk_now - tab_arr[i];
        endfunction

        function void note_input(logic op, logic [1:0] kind, logic [4:0] burst);
            t_result r;
            int sel, mode;
            logic [4:0] slice, rem;
            logic demote;
            longint unsigned a, b;
            logic [15:0] t_id; logic [1:0] t_kind, t_lvl;
            logic [4:0] t_burst; logic [31:0] t_arr, t_wait;
            r = '{default: '0};
            if (op == OP_SUBMIT) begin
                if (count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tab_id[count] = next_id; tab_kind[count] = kind;
                    tab_burst[count] = (burst == 0) ? 5'd1 : burst;
                    tab_left[count] = tab_burst[count];
                    tab_arr[count] = clk_now; tab_wait[count] = 0; tab_lvl[count] = 0;
                    count++;
                    r.id = next_id; next_id++;
                    r.status = ST_ACCEPT;
                end
            end else if (count == 0) begin
                clk_now++;
                r.status = ST_IDLE;
            end else begin
                sel = 0; mode = 0; slice = 0; demote = 0; r.start = 1;
                case (pol)
                    POL_RR: begin
                        mode = 1; slice = (rr_sl == 0) ? 5'd1 : rr_sl;
                    end
                    POL_SJF, POL_SRT: begin
                        for (int i = 1; i < count; i++)
                            if (tab_left[i] < tab_left[sel]) sel = i;
                        if (pol == POL_SRT) mode = 2;
                    end
                    POL_HRRN: begin
                        for (int i = 1; i < count; i++) begin
                            a = (longint'(tab_wait[i]) + tab_burst[i]) * tab_burst[sel];
                            b = (longint'(tab_wait[sel]) + tab_burst[sel]) * tab_burst[i];
                            if (a > b) sel = i;
                        end
                    end
                    POL_MLFQ: begin
                        for (int i = 1; i < count; i++)
                            if (tab_lvl[i] < tab_lvl[sel]) sel = i;
                        if (tab_lvl[sel] == 0) begin
                            mode = 1; demote = 1; slice = (top_sl == 0) ? 5'd1 : top_sl;
                        end else if (tab_lvl[sel] == 1) begin
                            mode = 1; demote = 1; slice = (mid_sl == 0) ? 5'd1 : mid_sl;
                        end
                    end
                    default: ;
                endcase
                r.id = tab_id[sel]; r.kind = tab_kind[sel];
                if (mode == 2) begin
                    r.start = !(last_srt[16] && last_srt[15:0] == r.id);
                    last_srt = {1'b1, r.id};
                    r.run = 1;
                    tab_left[sel]--;
                    r.left = tab_left[sel];
                    clk_now++;
                    if (r.left == 0) begin
                        remove_at(sel); update_waits(-1); r.done = 1;
                    end else begin
                        update_waits(sel);
                    end
                end else if (mode == 1 && tab_left[sel] > slice) begin
                    t_id = tab_id[sel]; t_kind = tab_kind[sel]; t_burst = tab_burst[sel];
                    t_arr = tab_arr[sel]; t_wait = tab_wait[sel]; t_lvl = tab_lvl[sel];
                    r.run = slice;
                    rem = tab_left[sel] - slice;
                    r.left = rem;
                    clk_now += slice;
                    remove_at(sel);
                    update_waits(-1);
                    if (demote && t_lvl < 2) t_lvl++;
                    tab_id[count] = t_id; tab_kind[count] = t_kind;
                    tab_burst[count] = t_burst; tab_left[count] = rem;
                    tab_arr[count] = t_arr; tab_wait[count] = t_wait;
                    tab_lvl[count] = t_lvl;
                    count++;
                end else begin
                    r.run = tab_left[sel];
                    clk_now += tab_left[sel];
                    remove_at(sel); update_waits(-1); r.done = 1;
                end
                r.status = ST_DISP;
            end
            r.now = clk_now;
            r.pending = count[4:0];
            expected_q.push_back(r);
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result act);
            t_result e;
            if (expected_q.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("status", e.status, act.status);
            cmp("job_id", e.id, act.id);
            cmp("job_type_out", e.kind, act.kind);
            cmp("run_ticks", e.run, act.run);
            cmp("left_ticks", e.left, act.left);
            cmp("start_note", e.start, act.start);
            cmp("done_note", e.done, act.done);
            cmp("now_ticks", e.now, act.now);
            cmp("pending", e.pending, act.pending);
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid;
    logic [0:0]  i_opcode;
    logic [1:0]  i_job_kind, i_cfg_index, o_status, o_job_type_out;
    logic [4:0]  i_burst_len, i_cfg_data, o_run_ticks, o_left_ticks, o_pending;
    logic        i_cfg_we, o_start_note, o_done_note;
    logic [15:0] o_job_id;
    logic [31:0] o_now_ticks;

    multi_policy_job_scheduler_core dut (.*);

    sched_scoreboard sb = new();
    int snd_idle, rcv_idle, quiet_cycles;
    bit hold_req;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result act;
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_opcode, i_job_kind, i_burst_len);
            if (o_valid && !i_stall) begin
                act.status = o_status; act.id = o_job_id; act.kind = o_job_type_out;
                act.run = o_run_ticks; act.left = o_left_ticks;
                act.start = o_start_note; act.done = o_done_note;
                act.now = o_now_ticks; act.pending = o_pending;
                sb.check_result(act);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1;
                repeat (300) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < rcv_idle);
        end
    end

    task automatic send(logic op, logic [1:0] kind, logic [4:0] burst);
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_opcode <= op; i_job_kind <= kind; i_burst_len <= burst;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [4:0] pick_slice();
        case ($urandom_range(0, 3))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd1;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        int sub_pct;
        i_rst_n = 0; i_valid = 0; i_opcode = 0; i_job_kind = 0; i_burst_len = 0;
        i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        snd_idle = 0; rcv_idle = 0; hold_req = 0; quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset config, idle dispatch, burst extremes, zero burst
        send(1, 0, 0);
        send(0, 0, 0);
        send(0, 2, 31);
        send(0, 1, 21);
        send(0, 2, 10);
        send(1, 0, 0);
        send(1, 0, 0);
        send(1, 0, 0);
        send(1, 0, 0);
        send(1, 0, 0);
        drain();

        for (int ph = 0; ph < 21; ph++) begin
            snd_idle = (ph < 7) ? 27 : (ph < 14) ? 67 : 0;
            rcv_idle = (ph < 7) ? 67 : (ph < 14) ? 27 : 0;
            write_reg(CFG_POLICY, 5'(ph % 8));
            write_reg(CFG_RR, pick_slice());
            write_reg(CFG_TOP, pick_slice());
            write_reg(CFG_MID, pick_slice());
            case (ph % 3)
                0: sub_pct = 75;
                1: sub_pct = 50;
                default: sub_pct = 35;
            endcase
            if (ph == 4 || ph == 16) hold_req = 1;
            for (int n = 0; n < 50; n++)
                send($urandom_range(0, 99) >= sub_pct, 2'($urandom_range(0, 2)),
                     5'($urandom_range(0, 31)));
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
